// ----- sv/sbsr_pkg.sv -----
`default_nettype none
package sbsr_pkg;

    localparam int DATA_W         = 32;
    localparam int START_W        = 10;
    localparam int DEF_MAX_ORDER  = 1024;
    localparam int DEF_FRAC_BITS  = 16;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic                     is_pair;
        logic                     last;
        logic [START_W-1:0]       start;
        logic signed [DATA_W-1:0] d1;
        logic signed [DATA_W-1:0] up;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] er;
        logic signed [DATA_W-1:0] ei;
        logic signed [DATA_W-1:0] d2;
    } t_job;

endpackage
`default_nettype wire

// ----- sv/sbsr_front.sv -----
`default_nettype none
module sbsr_front #(
    parameter int MAX_ORDER = sbsr_pkg::DEF_MAX_ORDER
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic signed [31:0]              i_diag_entry,
    input  wire logic signed [31:0]              i_upper_entry,
    input  wire logic signed [31:0]              i_lower_entry,
    input  wire logic signed [31:0]              i_eig_real,
    input  wire logic signed [31:0]              i_eig_imag,
    input  wire logic                            i_is_last,
    output sbsr_pkg::t_job                       o_job,
    output logic                                 o_push
);
    import sbsr_pkg::*;

    localparam int ROW_W = (MAX_ORDER > 2) ? $clog2(MAX_ORDER) : 1;

    logic                     r_pending;
    logic [ROW_W-1:0]         r_row;
    logic signed [DATA_W-1:0] r_diag, r_upper, r_lower, r_er, r_ei;

    logic [ROW_W:0]           sum_row;
    logic [ROW_W:0]           wrap_row;
    logic [ROW_W+START_W-1:0] row_ext;
    logic                     opens;

    assign opens   = !r_pending && !i_is_last && (i_lower_entry != '0);
    assign sum_row = {1'b0, r_row} + (r_pending ? (ROW_W+1)'(2) : (ROW_W+1)'(1));
    assign wrap_row = (sum_row >= (ROW_W+1)'(MAX_ORDER)) ?
                      sum_row - (ROW_W+1)'(MAX_ORDER) : sum_row;
    assign row_ext = {{START_W{1'b0}}, r_row};

    always_comb begin
        o_job.is_pair = r_pending;
        o_job.last    = i_is_last;
        o_job.start   = row_ext[START_W-1:0];
        o_job.d1      = r_pending ? r_diag : i_diag_entry;
        o_job.up      = r_upper;
        o_job.lo      = r_lower;
        o_job.er      = r_er;
        o_job.ei      = r_ei;
        o_job.d2      = i_diag_entry;
        o_push        = i_accept && !opens;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_row     <= '0;
            r_diag    <= '0;
            r_upper   <= '0;
            r_lower   <= '0;
            r_er      <= '0;
            r_ei      <= '0;
        end else if (i_accept) begin
            if (opens) begin
                r_pending <= 1'b1;
                r_diag    <= i_diag_entry;
                r_upper   <= i_upper_entry;
                r_lower   <= i_lower_entry;
                r_er      <= i_eig_real;
                r_ei      <= i_eig_imag;
            end else begin
                r_pending <= 1'b0;
                r_row     <= i_is_last ? '0 : wrap_row[ROW_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/sbsr_queue.sv -----
`default_nettype none
module sbsr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  sbsr_pkg::t_job      i_job,
    input  wire logic           i_pop,
    output sbsr_pkg::t_job      o_job,
    output logic                o_empty,
    output logic                o_full
);
    import sbsr_pkg::*;

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

// ----- sv/sbsr_back.sv -----
`default_nettype none
module sbsr_back #(
    parameter int FRAC_BITS = sbsr_pkg::DEF_FRAC_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  sbsr_pkg::t_job          i_job,
    input  wire logic               i_empty,
    output logic                    o_pop,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output logic [9:0]              o_block_start,
    output logic                    o_is_pair,
    output logic signed [31:0]      o_root_11_real,
    output logic signed [31:0]      o_root_11_imag,
    output logic signed [31:0]      o_root_12,
    output logic signed [31:0]      o_root_21,
    output logic signed [31:0]      o_root_22,
    output logic                    o_saturated,
    output logic                    o_last_block
);
    import sbsr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MULA, S_MULB, S_SQRT, S_DIV, S_DONE
    } t_state;

    typedef enum logic [1:0] {P_ONE, P_MAG, P_R} t_phase;

    t_state r_state;
    t_phase r_phase;
    t_job   r_job;

    logic [63:0]              r_acc;
    logic [63:0]              r_sq_x;
    logic [33:0]              r_sq_rem;
    logic [31:0]              r_sq_root;
    logic [4:0]               r_sq_cnt;
    logic [31:0]              r_r;
    logic signed [33:0]       r_num [4];
    logic signed [31:0]       r_el [4];
    logic [1:0]               r_k;
    logic [63:0]              r_dv_n;
    logic [31:0]              r_dv_rem;
    logic [5:0]               r_dv_cnt;
    logic                     r_sat;

    // square root: one result bit per cycle
    logic [35:0] sq_sh, sq_trial;
    logic        sq_ge;
    assign sq_sh    = {r_sq_rem, r_sq_x[63:62]};
    assign sq_trial = {2'b00, r_sq_root, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    logic [31:0] root_nxt;
    assign root_nxt = {r_sq_root[30:0], sq_ge};

    // restoring divide by 2r: one quotient bit per cycle
    logic [32:0] dv_sh, dv_d;
    logic        dv_ge;
    logic [63:0] dv_q;
    assign dv_sh = {r_dv_rem, r_dv_n[63]};
    assign dv_d  = {r_r, 1'b0};
    assign dv_ge = (dv_sh >= dv_d);
    assign dv_q  = {r_dv_n[62:0], dv_ge};

    logic signed [33:0] num_k;
    logic               num_neg;
    logic signed [63:0] q_signed, el64;
    logic               el_sat;
    logic [31:0]        el32;
    assign num_k    = r_num[r_k];
    assign num_neg  = num_k[33];
    assign q_signed = num_neg ? -$signed(dv_q) : $signed(dv_q);
    assign el64     = q_signed + (((r_k == 2'd0) || (r_k == 2'd3)) ?
                      $signed({32'd0, r_r}) : 64'sd0);
    assign el_sat   = (el64 > S32_MAX) || (el64 < S32_MIN);
    assign el32     = (el64 > S32_MAX) ? S32_MAX[31:0] :
                      (el64 < S32_MIN) ? S32_MIN[31:0] : el64[31:0];

    // mag + Re(ev) is never negative
    logic signed [33:0] mag_plus;
    logic [63:0]        inner;
    assign mag_plus = $signed({2'b00, root_nxt}) + 34'(r_job.er);
    assign inner    = ({30'd0, mag_plus[33:0]} << FRAC_BITS) >> 1;

    logic signed [63:0] sq_a, sq_b;
    assign sq_a = r_job.er * r_job.er;
    assign sq_b = r_job.ei * r_job.ei;

    logic [63:0] single_x;
    logic [31:0] d_abs;
    assign d_abs    = i_job.d1[31] ? 32'(-i_job.d1) : i_job.d1;
    assign single_x = {32'd0, d_abs} << FRAC_BITS;

    logic out_free;
    assign out_free = !o_out_valid || !i_out_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    function automatic logic [63:0] n_load(input logic signed [33:0] n);
        logic signed [33:0] a;
        a = n[33] ? -n : n;
        return {30'd0, a} << FRAC_BITS;
    endfunction

    function automatic logic [31:0] zsat(input logic signed [33:0] n);
        if (n > 34'sd0)      return S32_MAX[31:0];
        else if (n < 34'sd0) return S32_MIN[31:0];
        else                 return 32'd0;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) o_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job    <= i_job;
                        r_sat    <= 1'b0;
                        r_sq_rem <= '0;
                        r_sq_root <= '0;
                        r_sq_cnt <= '0;
                        r_num[0] <= 34'(i_job.d1) - 34'(i_job.er);
                        r_num[1] <= 34'(i_job.up);
                        r_num[2] <= 34'(i_job.lo);
                        r_num[3] <= 34'(i_job.d2) - 34'(i_job.er);
                        if (i_job.is_pair) begin
                            r_state <= S_MULA;
                        end else begin
                            r_sq_x  <= single_x;
                            r_phase <= P_ONE;
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_MULA: begin
                    r_acc   <= sq_a;
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    r_sq_x  <= r_acc + sq_b;
                    r_phase <= P_MAG;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_sq_x    <= {r_sq_x[61:0], 2'b00};
                    r_sq_rem  <= sq_ge ? 34'(sq_sh - sq_trial) : sq_sh[33:0];
                    r_sq_root <= root_nxt;
                    r_sq_cnt  <= r_sq_cnt + 5'd1;
                    if (r_sq_cnt == 5'd31) begin
                        unique case (r_phase)
                            P_ONE: begin
                                r_el[0] <= r_job.d1[31] ? 32'd0 : root_nxt;
                                r_el[1] <= '0;
                                r_el[2] <= '0;
                                r_el[3] <= r_job.d1[31] ? root_nxt : 32'd0;
                                r_state <= S_DONE;
                            end
                            P_MAG: begin
                                r_sq_x    <= inner;
                                r_sq_rem  <= '0;
                                r_sq_root <= '0;
                                r_phase   <= P_R;
                            end
                            default: begin
                                r_r <= root_nxt;
                                if (root_nxt == 32'd0) begin
                                    r_sat   <= 1'b1;
                                    r_el[0] <= zsat(r_num[0]);
                                    r_el[1] <= zsat(r_num[1]);
                                    r_el[2] <= zsat(r_num[2]);
                                    r_el[3] <= zsat(r_num[3]);
                                    r_state <= S_DONE;
                                end else begin
                                    r_k      <= 2'd0;
                                    r_dv_n   <= n_load(r_num[0]);
                                    r_dv_rem <= '0;
                                    r_dv_cnt <= '0;
                                    r_state  <= S_DIV;
                                end
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_dv_n   <= dv_q;
                    r_dv_rem <= dv_ge ? 32'(dv_sh - dv_d) : dv_sh[31:0];
                    r_dv_cnt <= r_dv_cnt + 6'd1;
                    if (r_dv_cnt == 6'd63) begin
                        r_el[r_k] <= el32;
                        if (el_sat) r_sat <= 1'b1;
                        r_k      <= r_k + 2'd1;
                        r_dv_n   <= n_load(r_num[r_k + 2'd1]);
                        r_dv_rem <= '0;
                        if (r_k == 2'd3) r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        o_out_valid    <= 1'b1;
                        o_block_start  <= r_job.start;
                        o_is_pair      <= r_job.is_pair;
                        o_root_11_real <= r_el[0];
                        o_root_12      <= r_job.is_pair ? r_el[1] : 32'd0;
                        o_root_21      <= r_job.is_pair ? r_el[2] : 32'd0;
                        o_root_22      <= r_job.is_pair ? r_el[3] : 32'd0;
                        o_root_11_imag <= r_job.is_pair ? 32'd0 : r_el[3];
                        o_saturated    <= r_sat;
                        o_last_block   <= r_job.last;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_single_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_pair) |->
        (o_root_12 == '0 && o_root_21 == '0 && o_root_22 == '0 && !o_saturated))
        else $error("1x1 result carries pair fields");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_r != '0))
        else $error("divide started with zero r");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_IDLE))
        else $error("popped job not taken up");

endmodule
`default_nettype wire

// ----- sv/schur_block_square_root.sv -----
// Square roots of the diagonal blocks of a quasi-triangular real Schur matrix.
// Input channel: i_in_valid / o_in_stall, one diagonal index per transfer,
// with the matrix entries, the eigenvalue and an end-of-matrix flag.
// A nonzero subdiagonal opens a 2x2 block finished by the next index; other
// indices are 1x1 blocks. One result transfer per block on o_out_valid /
// i_out_stall, in block order, fixed point with FRAC_BITS fraction bits.
// The front pairs indices and passes jobs through a two-entry queue, so it
// keeps taking indices while the back end works, until the queue is full.
// The back end runs one job at a time, from queue to output register, on
// a shared bit-serial square root and a restoring divider.
// A stalled result holds in the output register; the back end finishes the
// next job and waits for the register to free.
// Reset clears the pairing state, row counter, queue and output valid.
`default_nettype none
module schur_block_square_root #(
    parameter int MAX_ORDER = sbsr_pkg::DEF_MAX_ORDER,
    parameter int FRAC_BITS = sbsr_pkg::DEF_FRAC_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [31:0] i_diag_entry,
    input  wire logic signed [31:0] i_upper_entry,
    input  wire logic signed [31:0] i_lower_entry,
    input  wire logic signed [31:0] i_eig_real,
    input  wire logic signed [31:0] i_eig_imag,
    input  wire logic               i_is_last,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [9:0]              o_block_start,
    output logic                    o_is_pair,
    output logic signed [31:0]      o_root_11_real,
    output logic signed [31:0]      o_root_11_imag,
    output logic signed [31:0]      o_root_12,
    output logic signed [31:0]      o_root_21,
    output logic signed [31:0]      o_root_22,
    output logic                    o_saturated,
    output logic                    o_last_block
);
    import sbsr_pkg::*;

    t_job  push_job, pop_job;
    logic  q_push, q_full;
    logic  accept, pop, empty;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    sbsr_front #(.MAX_ORDER(MAX_ORDER)) u_front (
        .i_clk, .i_rst_n,
        .i_accept      (accept),
        .i_diag_entry, .i_upper_entry, .i_lower_entry,
        .i_eig_real, .i_eig_imag, .i_is_last,
        .o_job         (push_job),
        .o_push        (q_push)
    );

    sbsr_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty),
        .o_full  (q_full)
    );

    sbsr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_job   (pop_job),
        .i_empty (empty),
        .o_pop   (pop),
        .i_out_stall, .o_out_valid,
        .o_block_start, .o_is_pair,
        .o_root_11_real, .o_root_11_imag,
        .o_root_12, .o_root_21, .o_root_22,
        .o_saturated, .o_last_block
    );

endmodule
`default_nettype wire
